[hw/rtl/susp_pkg.sv]
package susp_pkg;

    // Entry signatures, first character in the upper byte.
    localparam logic [15:0] SIG_SP = 16'h5350;
    localparam logic [15:0] SIG_CE = 16'h4345;
    localparam logic [15:0] SIG_ER = 16'h4552;
    localparam logic [15:0] SIG_NM = 16'h4E4D;
    localparam logic [15:0] SIG_CL = 16'h434C;
    localparam logic [15:0] SIG_PL = 16'h504C;
    localparam logic [15:0] SIG_RE = 16'h5245;

    // SP magic as it sits in the low half of the field shifter (BE then EF).
    localparam logic [15:0] SP_MAGIC = 16'hEFBE;

    // NM flags that mark the current, parent and network names.
    localparam logic [7:0] NM_SKIP_FLAGS = 8'h26;

    // Area status codes.
    localparam logic [1:0] AREA_OPEN  = 2'd0;
    localparam logic [1:0] AREA_OK    = 2'd1;
    localparam logic [1:0] AREA_ERROR = 2'd2;

    // Identifier match bits: the nine-character name, then the two ten-character names.
    localparam int ID_MATCH_A = 0;
    localparam int ID_MATCH_B = 1;
    localparam int ID_MATCH_C = 2;

    // Result word layout.
    localparam int OUT_TDATA_W = 184;
    localparam int OUT_TUSER_W = 2;

    typedef struct packed {
        logic [OUT_TUSER_W-1:0] user;
        logic [OUT_TDATA_W-1:0] data;
    } result_t;

    // Characters of the nine-character standard identifier.
    function automatic logic [7:0] id_a_char(input logic [3:0] k);
        logic [7:0] c;
        case (k)
            4'd0, 4'd1, 4'd2, 4'd3: c = 8'h49;
            default: c = 8'h00;
        endcase
        case (k)
            4'd1, 4'd2, 4'd3: c = 8'h45;
            4'd4: c = 8'h5F;
            4'd5: c = 8'h31;
            4'd6: c = 8'h32;
            4'd7: c = 8'h38;
            4'd8: c = 8'h32;
            default: ;
        endcase
        return c;
    endfunction

    // Characters of the ten-character proposed standard identifier.
    function automatic logic [7:0] id_b_char(input logic [3:0] k);
        logic [7:0] c;
        case (k)
            4'd0: c = 8'h49;
            4'd1, 4'd2, 4'd3: c = 8'h45;
            4'd4: c = 8'h5F;
            4'd5: c = 8'h50;
            4'd6: c = 8'h31;
            4'd7: c = 8'h32;
            4'd8: c = 8'h38;
            4'd9: c = 8'h32;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of the ten-character interchange protocol identifier.
    function automatic logic [7:0] id_c_char(input logic [3:0] k);
        logic [7:0] c;
        case (k)
            4'd0, 4'd1: c = 8'h52;
            4'd2: c = 8'h49;
            4'd3: c = 8'h50;
            4'd4: c = 8'h5F;
            4'd5: c = 8'h31;
            4'd6, 4'd7: c = 8'h39;
            4'd8: c = 8'h31;
            4'd9: c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/susp_entry_parser.sv]
// Channel  Dir  tdata (low bit up)                          tlast        tuser
// s_       in   data_byte[7:0]                              last_byte    clear_context
// m_       out  name_byte, area_status, context_flags,     -            name_valid,
//               skip_length, cont_block, cont_offset,                    name_restart
//               cont_length, child_location, parent_location
//
// One byte is taken per cycle while s_tready is high; results are registered for output.
// The parse step is a single pass of compare and capture logic into the state registers.
// A two-word output buffer takes one more word while m_tready is low; s_tready drops once
// a word waits in the skid slot and rises as the output register takes that word over.
// Reset is synchronous on aresetn low and clears all parse and context state.
// Bytes that give no result (inside an entry, not last, not a name byte) emit no word.
module susp_entry_parser
    import susp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // data_byte[7:0]
    input  logic                   s_tlast,
    input  logic                   s_tuser,   // clear_context
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // name_byte[7:0], area_status[9:8], context_flags[13:10], skip_length[21:14],
    // cont_block[53:22], cont_offset[85:54], cont_length[117:86],
    // child_location[149:118], parent_location[181:150], zero pad[183:182]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [OUT_TUSER_W-1:0] m_tuser    // name_valid[0], name_restart[1]
);

    // Parse state.
    logic [7:0]  entry_position_reg, entry_position_next;
    logic [7:0]  entry_length_reg, entry_length_next;
    logic [15:0] entry_signature_reg, entry_signature_next;
    logic [7:0]  entry_version_reg, entry_version_next;
    logic [31:0] field_shifter_reg, field_shifter_next;
    logic [31:0] hold_offset_reg, hold_offset_next;
    logic [31:0] hold_length_reg, hold_length_next;
    logic [7:0]  ident_length_reg, ident_length_next;
    logic [2:0]  ident_matches_reg, ident_matches_next;
    logic        name_suppressed_reg, name_suppressed_next;
    logic        parse_stopped_reg, parse_stopped_next;
    logic        error_seen_reg, error_seen_next;

    // Context kept across areas.
    logic        sp_seen_reg, sp_seen_next;
    logic        rock_ridge_seen_reg, rock_ridge_seen_next;
    logic        relocated_seen_reg, relocated_seen_next;
    logic [7:0]  skip_count_reg, skip_count_next;
    logic [31:0] ce_block_reg, ce_block_next;
    logic [31:0] ce_offset_reg, ce_offset_next;
    logic [31:0] ce_length_reg, ce_length_next;
    logic [31:0] child_reg, child_next;
    logic [31:0] parent_reg, parent_next;
    logic        name_present_reg, name_present_next;
    logic        name_continue_reg, name_continue_next;

    // Output buffer.
    logic        out_valid_reg, skid_valid_reg;
    result_t     out_data_reg, skid_data_reg;

    logic        s_accept;
    logic        has_result;
    result_t     result;
    logic        out_free;

    // Step temporaries.
    logic [7:0]  pos;
    logic [7:0]  kidx;
    logic [4:0]  lane_shift;
    logic [31:0] lane_word;
    logic        nv, nr, done, err_eff;
    logic [1:0]  status;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    // One parse step for the byte at the input.
    always_comb begin
        entry_position_next  = entry_position_reg;
        entry_length_next    = entry_length_reg;
        entry_signature_next = entry_signature_reg;
        entry_version_next   = entry_version_reg;
        field_shifter_next   = field_shifter_reg;
        hold_offset_next     = hold_offset_reg;
        hold_length_next     = hold_length_reg;
        ident_length_next    = ident_length_reg;
        ident_matches_next   = ident_matches_reg;
        name_suppressed_next = name_suppressed_reg;
        parse_stopped_next   = parse_stopped_reg;
        error_seen_next      = error_seen_reg;
        sp_seen_next         = sp_seen_reg;
        rock_ridge_seen_next = rock_ridge_seen_reg;
        relocated_seen_next  = relocated_seen_reg;
        skip_count_next      = skip_count_reg;
        ce_block_next        = ce_block_reg;
        ce_offset_next       = ce_offset_reg;
        ce_length_next       = ce_length_reg;
        child_next           = child_reg;
        parent_next          = parent_reg;
        name_present_next    = name_present_reg;
        name_continue_next   = name_continue_reg;

        // A new directory record starts from the reset state.
        if (s_tuser) begin
            entry_position_next  = '0;
            entry_length_next    = '0;
            entry_signature_next = '0;
            entry_version_next   = '0;
            field_shifter_next   = '0;
            hold_offset_next     = '0;
            hold_length_next     = '0;
            ident_length_next    = '0;
            ident_matches_next   = '1;
            name_suppressed_next = 1'b0;
            parse_stopped_next   = 1'b0;
            error_seen_next      = 1'b0;
            sp_seen_next         = 1'b0;
            rock_ridge_seen_next = 1'b0;
            relocated_seen_next  = 1'b0;
            skip_count_next      = '0;
            ce_block_next        = '0;
            ce_offset_next       = '0;
            ce_length_next       = '0;
            child_next           = '0;
            parent_next          = '0;
            name_present_next    = 1'b0;
            name_continue_next   = 1'b0;
        end

        pos        = entry_position_next;
        kidx       = pos - 8'd8;
        lane_shift = {pos[1:0], 3'b000};
        lane_word  = {24'd0, s_tdata} << lane_shift;
        nv         = 1'b0;
        nr         = 1'b0;
        done       = 1'b0;

        if (!parse_stopped_next) begin
            if (pos == 8'd0) begin
                entry_signature_next = {s_tdata, 8'h00};
                name_suppressed_next = 1'b0;
            end else if (pos == 8'd1) begin
                entry_signature_next = {entry_signature_next[15:8], s_tdata};
            end else if (pos == 8'd2) begin
                entry_length_next = s_tdata;
                if (s_tdata == 8'd0) begin
                    parse_stopped_next = 1'b1;
                end else if (s_tdata < 8'd4) begin
                    error_seen_next    = 1'b1;
                    parse_stopped_next = 1'b1;
                    name_present_next  = 1'b0;
                    name_continue_next = 1'b0;
                end
            end else begin
                // Field capture by byte position.
                if (pos == 8'd3) begin
                    entry_version_next = s_tdata;
                    field_shifter_next = '0;
                    hold_offset_next   = '0;
                    hold_length_next   = '0;
                    ident_length_next  = '0;
                    ident_matches_next = '1;
                end else if (pos <= 8'd7) begin
                    field_shifter_next = field_shifter_next | lane_word;
                    if (pos == 8'd4) begin
                        ident_length_next = s_tdata;
                        if (entry_signature_next == SIG_NM &&
                            (s_tdata & NM_SKIP_FLAGS) != 8'd0) begin
                            name_suppressed_next = 1'b1;
                        end
                    end
                end else if (pos >= 8'd12 && pos <= 8'd15) begin
                    hold_offset_next = hold_offset_next | lane_word;
                end else if (pos >= 8'd20 && pos <= 8'd23) begin
                    hold_length_next = hold_length_next | lane_word;
                end

                // ER identifier compare against the three known names.
                if (pos >= 8'd8) begin
                    if (kidx < 8'd9 && s_tdata != id_a_char(kidx[3:0])) begin
                        ident_matches_next[ID_MATCH_A] = 1'b0;
                    end
                    if (kidx < 8'd10 && s_tdata != id_b_char(kidx[3:0])) begin
                        ident_matches_next[ID_MATCH_B] = 1'b0;
                    end
                    if (kidx < 8'd10 && s_tdata != id_c_char(kidx[3:0])) begin
                        ident_matches_next[ID_MATCH_C] = 1'b0;
                    end
                end

                // Name bytes stream out as they arrive.
                if (entry_signature_next == SIG_NM && pos >= 8'd5 && !name_suppressed_next) begin
                    nv = 1'b1;
                    nr = (pos == 8'd5) && !(name_present_next && name_continue_next);
                end

                // The entry takes effect on its final byte.
                if ({1'b0, pos} + 9'd1 == {1'b0, entry_length_next}) begin
                    done = 1'b1;
                    case (entry_signature_next)
                        SIG_SP: begin
                            if (field_shifter_next[15:0] == SP_MAGIC) begin
                                skip_count_next = field_shifter_next[23:16];
                                sp_seen_next    = 1'b1;
                            end else begin
                                error_seen_next    = 1'b1;
                                parse_stopped_next = 1'b1;
                                name_present_next  = 1'b0;
                                name_continue_next = 1'b0;
                            end
                        end
                        SIG_CE: begin
                            ce_block_next  = field_shifter_next;
                            ce_offset_next = hold_offset_next;
                            ce_length_next = hold_length_next;
                        end
                        SIG_ER: begin
                            if (entry_version_next != 8'd1) begin
                                error_seen_next    = 1'b1;
                                parse_stopped_next = 1'b1;
                                name_present_next  = 1'b0;
                                name_continue_next = 1'b0;
                            end else if ((ident_length_next == 8'd9 &&
                                          ident_matches_next[ID_MATCH_A] &&
                                          entry_length_next >= 8'd17) ||
                                         (ident_length_next == 8'd10 &&
                                          (ident_matches_next[ID_MATCH_B] ||
                                           ident_matches_next[ID_MATCH_C]) &&
                                          entry_length_next >= 8'd18)) begin
                                rock_ridge_seen_next = 1'b1;
                            end
                        end
                        SIG_NM: begin
                            if (entry_length_next > 8'd5 && !name_suppressed_next) begin
                                name_present_next  = 1'b1;
                                name_continue_next = field_shifter_next[0];
                            end
                        end
                        SIG_CL: begin
                            child_next = field_shifter_next;
                        end
                        SIG_PL: begin
                            if (parent_next != 32'd0) begin
                                error_seen_next    = 1'b1;
                                parse_stopped_next = 1'b1;
                                name_present_next  = 1'b0;
                                name_continue_next = 1'b0;
                            end else begin
                                parent_next = field_shifter_next;
                            end
                        end
                        SIG_RE: begin
                            if (entry_length_next == 8'd4 && entry_version_next == 8'd1) begin
                                relocated_seen_next = 1'b1;
                            end else begin
                                error_seen_next    = 1'b1;
                                parse_stopped_next = 1'b1;
                                name_present_next  = 1'b0;
                                name_continue_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            if (done) begin
                entry_position_next = '0;
            end else if (!parse_stopped_next) begin
                entry_position_next = pos + 8'd1;
            end

            // The area ended inside an entry.
            if (s_tlast && !parse_stopped_next && !done && pos != 8'd0) begin
                error_seen_next    = 1'b1;
                parse_stopped_next = 1'b1;
                name_present_next  = 1'b0;
                name_continue_next = 1'b0;
            end
        end

        err_eff  = error_seen_next;
        if (!s_tlast) begin
            status = AREA_OPEN;
        end else if (err_eff) begin
            status = AREA_ERROR;
        end else begin
            status = AREA_OK;
        end

        // Position, stop and error state clear at the end of the area; context stays.
        if (s_tlast) begin
            entry_position_next = '0;
            parse_stopped_next  = 1'b0;
            error_seen_next     = 1'b0;
        end

        has_result  = nv || s_tlast;
        result.user = {nr, nv};
        result.data = {2'b00, parent_next, child_next, ce_length_next, ce_offset_next,
                       ce_block_next, skip_count_next,
                       name_continue_next, relocated_seen_next, rock_ridge_seen_next,
                       sp_seen_next, status, (nv ? s_tdata : 8'h00)};
    end

    // State update on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_position_reg  <= '0;
            entry_length_reg    <= '0;
            entry_signature_reg <= '0;
            entry_version_reg   <= '0;
            field_shifter_reg   <= '0;
            hold_offset_reg     <= '0;
            hold_length_reg     <= '0;
            ident_length_reg    <= '0;
            ident_matches_reg   <= '1;
            name_suppressed_reg <= 1'b0;
            parse_stopped_reg   <= 1'b0;
            error_seen_reg      <= 1'b0;
            sp_seen_reg         <= 1'b0;
            rock_ridge_seen_reg <= 1'b0;
            relocated_seen_reg  <= 1'b0;
            skip_count_reg      <= '0;
            ce_block_reg        <= '0;
            ce_offset_reg       <= '0;
            ce_length_reg       <= '0;
            child_reg           <= '0;
            parent_reg          <= '0;
            name_present_reg    <= 1'b0;
            name_continue_reg   <= 1'b0;
        end else if (s_accept) begin
            entry_position_reg  <= entry_position_next;
            entry_length_reg    <= entry_length_next;
            entry_signature_reg <= entry_signature_next;
            entry_version_reg   <= entry_version_next;
            field_shifter_reg   <= field_shifter_next;
            hold_offset_reg     <= hold_offset_next;
            hold_length_reg     <= hold_length_next;
            ident_length_reg    <= ident_length_next;
            ident_matches_reg   <= ident_matches_next;
            name_suppressed_reg <= name_suppressed_next;
            parse_stopped_reg   <= parse_stopped_next;
            error_seen_reg      <= error_seen_next;
            sp_seen_reg         <= sp_seen_next;
            rock_ridge_seen_reg <= rock_ridge_seen_next;
            relocated_seen_reg  <= relocated_seen_next;
            skip_count_reg      <= skip_count_next;
            ce_block_reg        <= ce_block_next;
            ce_offset_reg       <= ce_offset_next;
            ce_length_reg       <= ce_length_next;
            child_reg           <= child_next;
            parent_reg          <= parent_next;
            name_present_reg    <= name_present_next;
            name_continue_reg   <= name_continue_next;
        end
    end

    // Output register with a skid word behind it.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= s_accept && has_result;
            end else begin
                out_valid_reg  <= s_accept && has_result;
            end
        end else if (s_accept && has_result) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= result;
            end else begin
                out_data_reg  <= result;
            end
        end else if (s_accept && has_result) begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.data;
    assign m_tuser  = out_data_reg.user;

    // The skid word is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    // An error always stops parsing until the area ends.
    a_error_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        error_seen_reg |-> parse_stopped_reg)
        else $error("error seen while parsing continues");

    // Within an entry body the position stays below the entry length.
    a_pos_in_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (entry_position_reg >= 8'd3) |-> (entry_position_reg < entry_length_reg))
        else $error("entry position ran past entry length");

    // The last byte of an area leaves a clean parse state.
    a_area_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=>
            (!parse_stopped_reg && !error_seen_reg && entry_position_reg == 8'd0))
        else $error("parse state not cleared after last byte");

endmodule
